>>> design/bfa_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the bitmap frame allocator: request kinds, status codes,
// field widths and configuration register decode. No dependencies.
package bfa_pkg;

  localparam int FRAME_W   = 16;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 17;
  localparam int FCOUNT_W  = 17;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEST    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MAPPED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 3'd4;

  // Register index is paddr bit 2 (4-byte registers)
  localparam logic REG_FRAME_COUNT = 1'b0;
  localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST = 17'h10000;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

>>> design/bitmap_frame_allocator.sv
`timescale 1ns / 1ps
// Bitmap frame allocator top level: usage bitmap memory, request sequencer,
// word scan unit and APB register. Depends on bfa_pkg.

// After reset the block sweeps the bitmap memory to zero, one word per cycle,
// so busy stays high until every word is cleared, and no request is taken
// before then; configuration writes are taken during the sweep.
// Free, test, reserve and an allocate that is already mapped pass through
// S_DIVA, S_DIVB and S_LOOK, and the result is registered onto done_o. An
// allocate that must search reads one bitmap word per cycle through the
// single memory read port and the scan unit, and stops at the first word
// holding a free frame. With no free frame it reports ST_FULL once the words
// below the frame count (clamped to MAX_FRAMES) are scanned, and without
// reading a word when the frame count is zero. Results appear for one cycle
// on done_o and cannot be held off; busy is low again in that same cycle.
module bitmap_frame_allocator #(
  parameter int MAX_FRAMES = 65536,
  parameter int WORD_BITS  = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [bfa_pkg::KIND_W-1:0]          kind_i,
  input  logic [bfa_pkg::FRAME_W-1:0]         frame_i,
  output logic                                done_o,
  output logic [bfa_pkg::FRAME_W-1:0]         result_frame_o,
  output logic [bfa_pkg::STATUS_W-1:0]        status_o,
  output logic                                is_used_o,
  output logic [bfa_pkg::COUNT_W-1:0]         used_count_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bfa_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [bfa_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [bfa_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import bfa_pkg::*;

  localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int LIM_W     = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W     = (LIM_W > FCOUNT_W) ? LIM_W : FCOUNT_W;
  localparam int BASE_W    = CMP_W + 1;
  localparam int RECIP_SH  = 24;
  localparam int RECIP     = (1 << RECIP_SH) / WORD_BITS;
  localparam int PROD_W    = FRAME_W + RECIP_SH;
  localparam logic [FRAME_W-1:0] WB_F    = FRAME_W'(WORD_BITS);
  localparam logic [BASE_W-1:0]  WB_B    = BASE_W'(WORD_BITS);
  localparam logic [CMP_W-1:0]   MAX_C   = CMP_W'(MAX_FRAMES);
  localparam logic [AW-1:0]      LAST_W  = AW'(NUM_WORDS - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIVA  = 6'b000100,
    S_DIVB  = 6'b001000,
    S_LOOK  = 6'b010000,
    S_SCAN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration register
  logic [FCOUNT_W-1:0] frame_count_q;
  logic                cfg_wr;
  logic [CMP_W-1:0]    lim;
  logic [BASE_W-1:0]   lim_b;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_COUNT);
  assign prdata = (paddr[2] == REG_FRAME_COUNT) ?
                  APB_DATA_W'(frame_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RST;
    end else if (cfg_wr) begin
      frame_count_q <= pwdata[FCOUNT_W-1:0];
    end
  end

  assign lim   = (CMP_W'(frame_count_q) > MAX_C) ? MAX_C : CMP_W'(frame_count_q);
  assign lim_b = BASE_W'(lim);

  // Bitmap memory: one write port, one registered read port
  logic [WORD_BITS-1:0] bitmap_q [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= bitmap_q[mem_raddr];
    end
  end

  // Request and sequencer registers
  logic [KIND_W-1:0]    kind_q, kind_d;
  logic [FRAME_W-1:0]   frame_q, frame_d;
  logic [FRAME_W-1:0]   quot_q, quot_d;
  logic                 in_range_q, in_range_d;
  logic [AW-1:0]        word_q, word_d;
  logic [BW-1:0]        bit_q, bit_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [CMP_W-1:0]     count_q, count_d;

  // Scan pipeline: issue side and evaluate side
  logic [BASE_W-1:0]    rd_base_q, rd_base_d;
  logic [AW-1:0]        rd_addr_q, rd_addr_d;
  logic                 ev_valid_q, ev_valid_d;
  logic [BASE_W-1:0]    ev_base_q, ev_base_d;
  logic [AW-1:0]        ev_addr_q, ev_addr_d;
  logic [WORD_BITS-1:0] ev_mask_q, ev_mask_d;

  // Response registers
  logic                 done_q, done_d;
  logic [FRAME_W-1:0]   res_frame_q, res_frame_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic                 is_used_q, is_used_d;

  // Datapath helpers
  logic [PROD_W-1:0]    prod;
  logic [FRAME_W-1:0]   back_prod;
  logic [FRAME_W-1:0]   rem_raw;
  logic [FRAME_W-1:0]   quot_fix;
  logic [FRAME_W-1:0]   rem_fix;
  logic                 prev_used;
  logic [WORD_BITS-1:0] bit_onehot;
  logic                 issue;
  logic [BASE_W-1:0]    left;
  logic [WORD_BITS-1:0] masked;
  logic [WORD_BITS-1:0] free_onehot;
  logic                 word_full;
  logic [BW-1:0]        free_idx;

  assign prod      = PROD_W'(frame_q) * PROD_W'(RECIP);
  assign back_prod = quot_q * WB_F;
  assign rem_raw   = frame_q - back_prod;
  // Reciprocal estimate is at most one low
  assign quot_fix  = (rem_raw >= WB_F) ? quot_q + FRAME_W'(1) : quot_q;
  assign rem_fix   = (rem_raw >= WB_F) ? rem_raw - WB_F : rem_raw;

  assign bit_onehot = WORD_BITS'(1) << bit_q;
  assign prev_used  = in_range_q ? rdata_q[bit_q] : 1'b1;

  assign issue = (rd_base_q < lim_b);
  assign left  = lim_b - rd_base_q;

  // Scan unit: lowest zero bit of the word, frames past the limit as used
  assign masked      = rdata_q | ~ev_mask_q;
  assign word_full   = &masked;
  assign free_onehot = ~masked & (masked + WORD_BITS'(1));

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (free_onehot[i]) begin
        free_idx = free_idx | BW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    frame_d     = frame_q;
    quot_d      = quot_q;
    in_range_d  = in_range_q;
    word_d      = word_q;
    bit_d       = bit_q;
    clr_d       = clr_q;
    count_d     = count_q;
    rd_base_d   = rd_base_q;
    rd_addr_d   = rd_addr_q;
    ev_valid_d  = 1'b0;
    ev_base_d   = ev_base_q;
    ev_addr_d   = ev_addr_q;
    ev_mask_d   = ev_mask_q;
    done_d      = 1'b0;
    res_frame_d = res_frame_q;
    status_d    = status_q;
    is_used_d   = is_used_q;
    mem_we      = 1'b0;
    mem_waddr   = word_q;
    mem_wdata   = rdata_q;
    mem_re      = 1'b0;
    mem_raddr   = rd_addr_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_W) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          kind_d  = kind_i;
          frame_d = frame_i;
          state_d = S_DIVA;
        end
      end
      S_DIVA: begin
        quot_d     = prod[RECIP_SH +: FRAME_W];
        in_range_d = (CMP_W'(frame_q) < lim);
        state_d    = S_DIVB;
      end
      S_DIVB: begin
        word_d    = AW'(quot_fix);
        bit_d     = BW'(rem_fix);
        mem_re    = in_range_q;
        mem_raddr = AW'(quot_fix);
        state_d   = S_LOOK;
      end
      S_LOOK: begin
        state_d     = S_IDLE;
        done_d      = 1'b1;
        res_frame_d = frame_q;
        status_d    = ST_OK;
        is_used_d   = prev_used;
        unique case (kind_q)
          KIND_ALLOC: begin
            if (frame_q != '0) begin
              status_d = ST_MAPPED;
            end else begin
              // Start the word scan from frame zero
              done_d    = 1'b0;
              rd_base_d = '0;
              rd_addr_d = '0;
              state_d   = S_SCAN;
            end
          end
          KIND_FREE: begin
            if (!in_range_q) begin
              status_d = ST_RANGE;
            end else if (!prev_used) begin
              status_d = ST_NOT_USED;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = rdata_q & ~bit_onehot;
              if (count_q != '0) begin
                count_d = count_q - CMP_W'(1);
              end
            end
          end
          KIND_TEST: begin
            if (!in_range_q) begin
              status_d = ST_RANGE;
            end
          end
          KIND_RESERVE: begin
            if (!in_range_q) begin
              status_d = ST_RANGE;
            end else if (!prev_used) begin
              mem_we    = 1'b1;
              mem_wdata = rdata_q | bit_onehot;
              count_d   = count_q + CMP_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (ev_valid_q && !word_full) begin
          mem_we      = 1'b1;
          mem_waddr   = ev_addr_q;
          mem_wdata   = rdata_q | free_onehot;
          count_d     = count_q + CMP_W'(1);
          done_d      = 1'b1;
          res_frame_d = FRAME_W'(ev_base_q + BASE_W'(free_idx));
          status_d    = ST_OK;
          is_used_d   = 1'b0;
          state_d     = S_IDLE;
        end else if (!ev_valid_q && !issue) begin
          done_d      = 1'b1;
          res_frame_d = frame_q;
          status_d    = ST_FULL;
          is_used_d   = 1'b1;
          state_d     = S_IDLE;
        end else if (issue) begin
          // Fetch the next word while the current one is evaluated
          mem_re     = 1'b1;
          mem_raddr  = rd_addr_q;
          ev_valid_d = 1'b1;
          ev_base_d  = rd_base_q;
          ev_addr_d  = rd_addr_q;
          ev_mask_d  = (left >= WB_B) ? '1 : ~({WORD_BITS{1'b1}} << left[BW-1:0]);
          rd_base_d  = rd_base_q + WB_B;
          rd_addr_d  = rd_addr_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      count_q    <= '0;
      ev_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      count_q    <= count_d;
      ev_valid_q <= ev_valid_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    frame_q     <= frame_d;
    quot_q      <= quot_d;
    in_range_q  <= in_range_d;
    word_q      <= word_d;
    bit_q       <= bit_d;
    rd_base_q   <= rd_base_d;
    rd_addr_q   <= rd_addr_d;
    ev_base_q   <= ev_base_d;
    ev_addr_q   <= ev_addr_d;
    ev_mask_q   <= ev_mask_d;
    res_frame_q <= res_frame_d;
    status_q    <= status_d;
    is_used_q   <= is_used_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign result_frame_o = res_frame_q;
  assign status_o       = status_q;
  assign is_used_o      = is_used_q;
  assign used_count_o   = (count_q > CMP_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(count_q);

endmodule

>>> design/bfa_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the bitmap frame allocator and the bind that attaches
// them. Depends on bfa_pkg and bitmap_frame_allocator.
module bfa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           done_o,
  input logic [bfa_pkg::STATUS_W-1:0]   status_o,
  input logic                           is_used_o,
  input logic [bfa_pkg::COUNT_W-1:0]    used_count_o
);
  import bfa_pkg::*;

  // An accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted transaction");

  // One result per transaction, never two in a row
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // Full and out of range report the frame as used
  a_used_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL || status_o == ST_RANGE)) |-> is_used_o)
    else $error("is_used low on a full or out of range result");

  // Used frame count moves only with a result
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(used_count_o))
    else $error("used count changed without a result");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .is_used_o    (is_used_o),
  .used_count_o (used_count_o)
);
